>>> rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
// Package for the I2C master bit sequencer: word types, request codes and defaults.
// It depends on nothing. The front end, sequencer and top level use it by scoped names.
package i2cms_pkg;

	localparam int DELAY_COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF       = 2;
	localparam int PADDR_WIDTH           = 3;
	localparam int PDATA_WIDTH           = 32;

	localparam logic [15:0] PHASE_DELAY_RST    = 16'd8;
	localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd255;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_START = 3'd1;
	localparam logic [2:0] REQ_STOP  = 3'd2;
	localparam logic [2:0] REQ_WRITE = 3'd3;
	localparam logic [2:0] REQ_READ  = 3'd4;

	localparam logic REG_PHASE_DELAY    = 1'b0;
	localparam logic REG_ACK_POLL_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		KIND_NOP,
		KIND_TICK,
		KIND_START,
		KIND_STOP,
		KIND_WRITE,
		KIND_READ
	} kind_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] wr_data;
		logic       send_ack;
		logic       sda_in;
	} in_word_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] wr_data;
		logic       send_ack;
		logic       sda_in;
	} cmd_word_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_driven;
		logic       done_res;
		logic       ack_seen;
		logic [7:0] read_data;
		logic       rejected;
	} out_word_t;

	typedef struct packed {
		logic [15:0] phase_delay;
		logic [7:0]  ack_poll_limit;
	} cfg_t;

endpackage

>>> rtl/i2cms_fifo.sv
`timescale 1ns / 1ps
// Small synchronous queue with full and empty flags.
// It depends on nothing; the width and depth come from the instantiating module.
module i2cms_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/i2cms_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words and classifies the request code.
// It depends on i2cms_pkg and feeds the command queue.
module i2cms_front (
	input  logic                 push,
	input  i2cms_pkg::in_word_t  item,
	output logic                 full,
	output logic                 cmd_push,
	output i2cms_pkg::cmd_word_t cmd_word,
	input  logic                 cmd_full
);

	i2cms_pkg::kind_t kind;

	always_comb begin
		unique case (item.req_type)
			i2cms_pkg::REQ_TICK:  kind = i2cms_pkg::KIND_TICK;
			i2cms_pkg::REQ_START: kind = i2cms_pkg::KIND_START;
			i2cms_pkg::REQ_STOP:  kind = i2cms_pkg::KIND_STOP;
			i2cms_pkg::REQ_WRITE: kind = i2cms_pkg::KIND_WRITE;
			i2cms_pkg::REQ_READ:  kind = i2cms_pkg::KIND_READ;
			default:              kind = i2cms_pkg::KIND_NOP;
		endcase
	end

	assign full              = cmd_full;
	assign cmd_push          = push;
	assign cmd_word.kind     = kind;
	assign cmd_word.wr_data  = item.wr_data;
	assign cmd_word.send_ack = item.send_ack;
	assign cmd_word.sda_in   = item.sda_in;

endmodule

>>> rtl/i2cms_seq.sv
`timescale 1ns / 1ps
// Back end: the SCL/SDA phase sequencer, one classified word per cycle unless a queue stalls it.
// It depends on i2cms_pkg and sits between the command and result queues.
module i2cms_seq #(
	parameter int DELAY_COUNT_WIDTH = i2cms_pkg::DELAY_COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2cms_pkg::cfg_t      cfg,
	input  logic                 cmd_empty,
	input  i2cms_pkg::cmd_word_t cmd_word,
	output logic                 cmd_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output i2cms_pkg::out_word_t res_word
);

	localparam int DW = DELAY_COUNT_WIDTH;
	localparam int EW = (DW > 16) ? DW : 16;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST_A,
		PH_ST_B,
		PH_SP_A,
		PH_SP_B,
		PH_WR_PRE,
		PH_WR_LO,
		PH_WR_HI,
		PH_WR_REL,
		PH_WR_ACKD,
		PH_WR_POLL,
		PH_WR_END,
		PH_RD_PRE,
		PH_RD_HI,
		PH_RD_LO,
		PH_RD_AK,
		PH_RD_AKH
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [3:0]    bit_count_q, bit_count_d;
	logic [7:0]    shift_q, shift_d;
	logic [DW-1:0] delay_count_q, delay_count_d;
	logic [7:0]    poll_count_q, poll_count_d;
	logic          scl_q, scl_d;
	logic          sda_q, sda_d;
	logic          drv_q, drv_d;
	logic          ack_q, ack_d;
	logic          ack_to_send_q, ack_to_send_d;

	logic          fire;
	logic [DW-1:0] dly_load;
	logic [EW-1:0] pd_ext;
	logic [DW-1:0] dly_dec;
	logic [7:0]    poll_inc;
	logic [7:0]    poll_lim;
	logic [3:0]    bit_inc;
	logic          do_put;
	logic          do_poll;
	logic          done;
	logic          ackv;
	logic [7:0]    rdata;
	logic          rej;

	assign fire     = !cmd_empty && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;

	assign pd_ext   = EW'(cfg.phase_delay);
	assign dly_dec  = delay_count_q - DW'(1);
	assign poll_inc = poll_count_q + 8'd1;
	assign poll_lim = (cfg.ack_poll_limit == 8'd0) ? 8'd1 : cfg.ack_poll_limit;
	assign bit_inc  = bit_count_q + 4'd1;

	always_comb begin
		if (pd_ext == '0) begin
			dly_load = DW'(1);
		end else if (pd_ext > EW'({DW{1'b1}})) begin
			dly_load = '1;
		end else begin
			dly_load = pd_ext[DW-1:0];
		end
	end

	always_comb begin
		phase_d       = phase_q;
		bit_count_d   = bit_count_q;
		shift_d       = shift_q;
		delay_count_d = delay_count_q;
		poll_count_d  = poll_count_q;
		scl_d         = scl_q;
		sda_d         = sda_q;
		drv_d         = drv_q;
		ack_d         = ack_q;
		ack_to_send_d = ack_to_send_q;
		do_put        = 1'b0;
		do_poll       = 1'b0;
		done          = 1'b0;
		ackv          = 1'b0;
		rdata         = 8'd0;
		rej           = 1'b0;
		if (fire) begin
			case (cmd_word.kind)
				i2cms_pkg::KIND_START, i2cms_pkg::KIND_STOP,
				i2cms_pkg::KIND_WRITE, i2cms_pkg::KIND_READ: begin
					if (phase_q != PH_IDLE) begin
						rej = 1'b1;
					end else begin
						delay_count_d = dly_load;
						unique case (cmd_word.kind)
							i2cms_pkg::KIND_START: begin
								drv_d   = 1'b1;
								sda_d   = 1'b1;
								scl_d   = 1'b1;
								phase_d = PH_ST_A;
							end
							i2cms_pkg::KIND_STOP: begin
								drv_d   = 1'b1;
								sda_d   = 1'b0;
								scl_d   = 1'b1;
								phase_d = PH_SP_A;
							end
							i2cms_pkg::KIND_WRITE: begin
								shift_d      = cmd_word.wr_data;
								bit_count_d  = 4'd0;
								poll_count_d = 8'd0;
								phase_d      = PH_WR_PRE;
							end
							default: begin
								shift_d       = 8'd0;
								bit_count_d   = 4'd0;
								ack_to_send_d = cmd_word.send_ack;
								drv_d         = 1'b0;
								phase_d       = PH_RD_PRE;
							end
						endcase
					end
				end
				i2cms_pkg::KIND_TICK: begin
					if (phase_q == PH_WR_POLL) begin
						do_poll = 1'b1;
					end else if (phase_q != PH_IDLE) begin
						delay_count_d = dly_dec;
						if (dly_dec == '0) begin
							unique case (phase_q)
								PH_ST_A: begin
									sda_d         = 1'b0;
									delay_count_d = dly_load;
									phase_d       = PH_ST_B;
								end
								PH_ST_B: begin
									scl_d   = 1'b0;
									phase_d = PH_IDLE;
									done    = 1'b1;
								end
								PH_SP_A: begin
									sda_d         = 1'b1;
									delay_count_d = dly_load;
									phase_d       = PH_SP_B;
								end
								PH_SP_B: begin
									phase_d = PH_IDLE;
									done    = 1'b1;
								end
								PH_WR_PRE: begin
									do_put = 1'b1;
								end
								PH_WR_LO: begin
									scl_d         = 1'b1;
									delay_count_d = dly_load;
									phase_d       = PH_WR_HI;
								end
								PH_WR_HI: begin
									scl_d       = 1'b0;
									bit_count_d = bit_inc;
									if (bit_inc < 4'd8) begin
										do_put = 1'b1;
									end else begin
										drv_d         = 1'b0;
										delay_count_d = dly_load;
										phase_d       = PH_WR_REL;
									end
								end
								PH_WR_REL: begin
									scl_d         = 1'b1;
									delay_count_d = dly_load;
									phase_d       = PH_WR_ACKD;
								end
								PH_WR_ACKD: begin
									do_poll = 1'b1;
								end
								PH_WR_END: begin
									phase_d = PH_IDLE;
									done    = 1'b1;
									ackv    = ack_q;
								end
								PH_RD_PRE: begin
									scl_d         = 1'b1;
									delay_count_d = dly_load;
									phase_d       = PH_RD_HI;
								end
								PH_RD_HI: begin
									shift_d       = {shift_q[6:0], cmd_word.sda_in};
									scl_d         = 1'b0;
									delay_count_d = dly_load;
									phase_d       = PH_RD_LO;
								end
								PH_RD_LO: begin
									bit_count_d   = bit_inc;
									delay_count_d = dly_load;
									if (bit_inc < 4'd8) begin
										scl_d   = 1'b1;
										phase_d = PH_RD_HI;
									end else begin
										drv_d   = 1'b1;
										sda_d   = !ack_to_send_q;
										phase_d = PH_RD_AK;
									end
								end
								PH_RD_AK: begin
									scl_d         = 1'b1;
									delay_count_d = dly_load;
									phase_d       = PH_RD_AKH;
								end
								PH_RD_AKH: begin
									scl_d   = 1'b0;
									phase_d = PH_IDLE;
									done    = 1'b1;
									rdata   = shift_q;
								end
								default: begin
									phase_d = PH_IDLE;
								end
							endcase
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (do_put) begin
			sda_d         = shift_q[7];
			shift_d       = {shift_q[6:0], 1'b0};
			delay_count_d = dly_load;
			phase_d       = PH_WR_LO;
		end
		if (do_poll) begin
			poll_count_d = poll_inc;
			if (!cmd_word.sda_in || poll_inc >= poll_lim) begin
				ack_d         = !cmd_word.sda_in;
				scl_d         = 1'b0;
				drv_d         = 1'b1;
				delay_count_d = dly_load;
				phase_d       = PH_WR_END;
			end else begin
				phase_d = PH_WR_POLL;
			end
		end
	end

	assign res_word.scl_level  = scl_d;
	assign res_word.sda_level  = sda_d;
	assign res_word.sda_driven = drv_d;
	assign res_word.done_res   = done;
	assign res_word.ack_seen   = ackv;
	assign res_word.read_data  = rdata;
	assign res_word.rejected   = rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_count_q   <= 4'd0;
			shift_q       <= 8'd0;
			delay_count_q <= '0;
			poll_count_q  <= 8'd0;
			scl_q         <= 1'b1;
			sda_q         <= 1'b1;
			drv_q         <= 1'b1;
			ack_q         <= 1'b0;
			ack_to_send_q <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			bit_count_q   <= bit_count_d;
			shift_q       <= shift_d;
			delay_count_q <= delay_count_d;
			poll_count_q  <= poll_count_d;
			scl_q         <= scl_d;
			sda_q         <= sda_d;
			drv_q         <= drv_d;
			ack_q         <= ack_d;
			ack_to_send_q <= ack_to_send_d;
		end
	end

	// A running delay phase always has ticks left to count.
	a_delay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE && phase_q != PH_WR_POLL) |-> delay_count_q != '0)
		else $error("delay phase with zero count");

	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= 4'd8)
		else $error("bit count beyond one byte");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_word.done_res) |=> phase_q == PH_IDLE)
		else $error("command finished but sequencer not idle");

	a_ack_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_word.ack_seen) |-> res_word.done_res)
		else $error("ack reported outside the finishing word");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_word.rejected) |=> $stable(phase_q))
		else $error("rejected command changed the phase");

endmodule

>>> rtl/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// Top level of the I2C master bit sequencer: configuration registers and the
// front end, command queue, phase sequencer and result queue. Depends on i2cms_pkg.
//
// Usage: each input word carries a request (tick, start, stop, write, read) and
// the sampled SDA level. A word is taken when push is high and full is low.
// Start, stop, write and read are taken only while the sequencer is idle; one
// that arrives while busy yields a result word with rejected set. Ticks advance
// the running command; every delay phase lasts phase_delay ticks (one if 0).
// Every input word yields exactly one result word, which holds the SCL, SDA and
// SDA-drive levels after that word, plus done, ack and read data.
// A result word reaches result after its input word is registered in the command
// queue and the phase sequencer steps it into the result queue. One word per cycle
// is sustained while the receiver keeps popping, as the sequencer takes a word
// whenever the command queue holds one and the result queue has room.
// When the receiver stalls (pop low), the result queue and then the command
// queue fill, and full rises; nothing is lost.
// Reset idles the sequencer with SCL and SDA high and driven, empties both
// queues, and loads phase_delay = 8 and ack_poll_limit = 255.
// Registers (APB): phase_delay at 0x0, ack_poll_limit at 0x4.
module i2c_master_bit_sequencer #(
	parameter int DELAY_COUNT_WIDTH = i2cms_pkg::DELAY_COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH       = i2cms_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  i2cms_pkg::in_word_t                 item,
	output logic                                empty,
	input  logic                                pop,
	output i2cms_pkg::out_word_t                result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [i2cms_pkg::PADDR_WIDTH-1:0]   paddr,
	input  logic [i2cms_pkg::PDATA_WIDTH-1:0]   pwdata,
	output logic [i2cms_pkg::PDATA_WIDTH-1:0]   prdata,
	output logic                                pready
);

	i2cms_pkg::cfg_t      cfg_q;
	i2cms_pkg::cmd_word_t fe_word;
	i2cms_pkg::cmd_word_t cq_word;
	i2cms_pkg::out_word_t seq_word;
	logic                 fe_push;
	logic                 cq_full;
	logic                 cq_empty;
	logic                 cq_pop;
	logic                 rq_full;
	logic                 rq_push;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_delay    <= i2cms_pkg::PHASE_DELAY_RST;
			cfg_q.ack_poll_limit <= i2cms_pkg::ACK_POLL_LIMIT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == i2cms_pkg::REG_PHASE_DELAY) begin
				cfg_q.phase_delay <= pwdata[15:0];
			end else begin
				cfg_q.ack_poll_limit <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == i2cms_pkg::REG_ACK_POLL_LIMIT) begin
			prdata = {24'd0, cfg_q.ack_poll_limit};
		end else begin
			prdata = {16'd0, cfg_q.phase_delay};
		end
	end

	i2cms_front u_front (
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_push (fe_push),
		.cmd_word (fe_word),
		.cmd_full (cq_full)
	);

	i2cms_fifo #(
		.WIDTH ($bits(i2cms_pkg::cmd_word_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.wdata  (fe_word),
		.full   (cq_full),
		.pop    (cq_pop),
		.rdata  (cq_word),
		.empty  (cq_empty)
	);

	i2cms_seq #(
		.DELAY_COUNT_WIDTH (DELAY_COUNT_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cq_empty),
		.cmd_word  (cq_word),
		.cmd_pop   (cq_pop),
		.res_full  (rq_full),
		.res_push  (rq_push),
		.res_word  (seq_word)
	);

	i2cms_fifo #(
		.WIDTH ($bits(i2cms_pkg::out_word_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (seq_word),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
